/* rtl/arc_pkg.sv */
// Shared types, protocol constants and register indexes for the ARP
// responder and address cache. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package arc_pkg;

    // Default sizes
    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int PORTS_DEF         = 3;
    localparam int PORT_SLOTS        = 3;
    localparam int QUEUE_DEPTH       = 2;

    // ARP header values accepted
    localparam logic [15:0] HW_TYPE_ETH     = 16'h0001;
    localparam logic [15:0] PROTO_TYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  HW_LEN_MAC      = 8'd6;
    localparam logic [7:0]  PROTO_LEN_IPV4  = 8'd4;
    localparam logic [15:0] OP_REQUEST      = 16'd1;
    localparam logic [15:0] OP_REPLY        = 16'd2;

    // Input and result kinds
    localparam logic KIND_PACKET   = 1'b0;
    localparam logic KIND_LOOKUP   = 1'b1;
    localparam logic RESULT_REPLY  = 1'b0;
    localparam logic RESULT_LOOKUP = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_MAC_0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_IP_0   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_MAC_1  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_IP_1   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_MAC_2  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_IP_2   = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_MAC_IDX [PORT_SLOTS] =
        '{CFG_PORT_MAC_0, CFG_PORT_MAC_1, CFG_PORT_MAC_2};
    localparam logic [CFG_IDX_W-1:0] CFG_IP_IDX [PORT_SLOTS] =
        '{CFG_PORT_IP_0, CFG_PORT_IP_1, CFG_PORT_IP_2};

    // Work handed from front to back
    typedef enum logic [1:0] {
        CMD_LOOKUP,
        CMD_REQUEST,
        CMD_STORE
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] ip;        // lookup IP, or packet sender IP
        logic [47:0] mac;       // packet sender MAC
        logic [31:0] target_ip;
    } t_item;

    // Cache table word
    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
    } t_entry;

    // One result item
    typedef struct packed {
        logic        result_kind;
        logic [1:0]  reply_port;
        logic [47:0] reply_sender_mac;
        logic [31:0] reply_sender_ip;
        logic [47:0] reply_target_mac;
        logic [31:0] reply_target_ip;
        logic        hit;
        logic [47:0] hit_mac;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

/* rtl/arc_front.sv */
// Front end: takes input transfers, checks the ARP header and classifies
// each item into a lookup, request or store command. Uses arc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module arc_front (
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic          i_kind,
    input  wire logic [15:0]   i_hw_type,
    input  wire logic [15:0]   i_proto_type,
    input  wire logic [7:0]    i_hw_len,
    input  wire logic [7:0]    i_proto_len,
    input  wire logic [15:0]   i_opcode,
    input  wire logic [47:0]   i_sender_mac,
    input  wire logic [31:0]   i_sender_ip,
    input  wire logic [31:0]   i_target_ip,
    input  wire logic [31:0]   i_lookup_ip,
    input  wire logic          i_full,
    output logic               o_push,
    output arc_pkg::t_item     o_item
);

    logic well_formed;
    logic keep;

    // Header check and command decode
    always_comb begin
        well_formed = (i_hw_type == arc_pkg::HW_TYPE_ETH)
                   && (i_proto_type == arc_pkg::PROTO_TYPE_IPV4)
                   && (i_hw_len == arc_pkg::HW_LEN_MAC)
                   && (i_proto_len == arc_pkg::PROTO_LEN_IPV4);
        keep             = 1'b0;
        o_item.cmd       = arc_pkg::CMD_LOOKUP;
        o_item.ip        = i_sender_ip;
        o_item.mac       = i_sender_mac;
        o_item.target_ip = i_target_ip;
        if (i_kind == arc_pkg::KIND_LOOKUP) begin
            keep      = 1'b1;
            o_item.ip = i_lookup_ip;
        end else if (well_formed) begin
            if (i_opcode == arc_pkg::OP_REQUEST) begin
                keep       = 1'b1;
                o_item.cmd = arc_pkg::CMD_REQUEST;
            end else if (i_opcode == arc_pkg::OP_REPLY) begin
                keep       = 1'b1;
                o_item.cmd = arc_pkg::CMD_STORE;
            end
        end
    end

    // Dropped items are still taken; only kept ones enter the queue
    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full && keep;

endmodule

`default_nettype wire

/* rtl/arc_queue.sv */
// Short command queue between front end and back end.
// Uses arc_pkg for the item type and depth.
`timescale 1ns / 1ps
`default_nettype none

module arc_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire arc_pkg::t_item i_item,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_avail,
    output arc_pkg::t_item      o_item
);

    localparam int DEPTH = arc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    arc_pkg::t_item     r_slot [DEPTH];
    logic [PTR_W-1:0]   r_wp;
    logic [PTR_W-1:0]   r_rp;
    logic [CNT_W-1:0]   r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_avail = (r_count != '0);
    assign o_item  = r_slot[r_rp];

    // Pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/arc_back.sv */
// Back end: cache table with sequential search, reply generation per
// matching port, and the output register. Uses arc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module arc_back #(
    parameter int TABLE_ENTRIES = arc_pkg::TABLE_ENTRIES_DEF,
    parameter int PORTS         = arc_pkg::PORTS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_avail,
    input  wire arc_pkg::t_item i_item,
    output logic                o_pop,
    input  wire logic [2:0]     i_port_enable,
    input  wire logic [47:0]    i_port_mac [PORTS],
    input  wire logic [31:0]    i_port_ip [PORTS],
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output arc_pkg::t_result    o_result
);

    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int PORT_W = (PORTS > 1) ? $clog2(PORTS) : 1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_FINISH = 5'b00100,
        S_MATCH  = 5'b01000,
        S_EMIT   = 5'b10000
    } t_state;

    t_state             r_state;
    t_state             n_state;
    arc_pkg::t_item     r_item;
    logic [CNT_W-1:0]   r_fill;
    logic [CNT_W-1:0]   r_idx;
    logic               r_pend;
    logic [IDX_W-1:0]   r_pend_idx;
    logic               r_found;
    logic [IDX_W-1:0]   r_found_idx;
    logic [47:0]        r_found_mac;
    logic [PORTS-1:0]   r_match;
    logic               r_out_valid;
    arc_pkg::t_result   r_result;
    arc_pkg::t_result   n_result;

    arc_pkg::t_entry    r_table [TABLE_ENTRIES];
    arc_pkg::t_entry    r_rd_data;

    logic               issue;
    logic               hit_now;
    logic               slot_free;
    logic               out_load;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [PORT_W-1:0]  emit_sel;
    logic [PORTS-1:0]   match_rest;

    // Search pipeline: one read issued per cycle, compare on the next
    assign issue     = (r_idx < r_fill);
    assign hit_now   = r_pend && (r_rd_data.ip == r_item.ip);
    assign slot_free = !r_out_valid || i_out_ready;
    assign wr_addr   = r_found ? r_found_idx : r_fill[IDX_W-1:0];

    // Lowest matching port goes first
    always_comb begin
        emit_sel = '0;
        for (int p = PORTS - 1; p >= 0; p--) begin
            if (r_match[p]) begin
                emit_sel = PORT_W'(p);
            end
        end
        match_rest = r_match & ~(PORTS'(1) << emit_sel);
    end

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_result = '0;
        o_pop    = 1'b0;
        out_load = 1'b0;
        wr_en    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_avail) begin
                    o_pop   = 1'b1;
                    n_state = (i_item.cmd == arc_pkg::CMD_REQUEST) ? S_MATCH : S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (hit_now || (!r_pend && !issue)) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (r_item.cmd == arc_pkg::CMD_LOOKUP) begin
                    if (slot_free) begin
                        out_load             = 1'b1;
                        n_result.result_kind = arc_pkg::RESULT_LOOKUP;
                        n_result.hit         = r_found;
                        n_result.hit_mac     = r_found ? r_found_mac : '0;
                        n_result.last        = 1'b1;
                        n_state              = S_IDLE;
                    end
                end else begin
                    // update in place, or append while room remains
                    wr_en   = r_found || (r_fill < CNT_W'(TABLE_ENTRIES));
                    n_state = S_IDLE;
                end
            end
            S_MATCH: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (r_match == '0) begin
                    n_state = S_IDLE;
                end else if (slot_free) begin
                    out_load                  = 1'b1;
                    n_result.result_kind      = arc_pkg::RESULT_REPLY;
                    n_result.reply_port       = 2'(emit_sel);
                    n_result.reply_sender_mac = i_port_mac[emit_sel];
                    n_result.reply_sender_ip  = i_port_ip[emit_sel];
                    n_result.reply_target_mac = r_item.mac;
                    n_result.reply_target_ip  = r_item.ip;
                    n_result.last             = (match_rest == '0);
                    if (match_rest == '0) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_match     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_idx   <= '0;
                r_pend  <= 1'b0;
                r_found <= 1'b0;
            end
            if (r_state == S_SEARCH) begin
                r_idx  <= r_idx + CNT_W'(issue);
                r_pend <= issue;
                if (hit_now) begin
                    r_found <= 1'b1;
                end
            end
            if (wr_en && !r_found) begin
                r_fill <= r_fill + 1'b1;
            end
            if (r_state == S_MATCH) begin
                for (int p = 0; p < PORTS; p++) begin
                    r_match[p] <= i_port_enable[p] && (i_port_ip[p] == r_item.target_ip);
                end
            end else if (out_load && (r_state == S_EMIT)) begin
                r_match <= match_rest;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
        if (r_state == S_SEARCH) begin
            r_pend_idx <= r_idx[IDX_W-1:0];
            if (hit_now) begin
                r_found_idx <= r_pend_idx;
                r_found_mac <= r_rd_data.mac;
            end
        end
        if (out_load) begin
            r_result <= n_result;
        end
    end

    // Cache table, one write port and one read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[wr_addr] <= '{ip: r_item.ip, mac: r_item.mac};
        end
        r_rd_data <= r_table[r_idx[IDX_W-1:0]];
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

`default_nettype wire

/* rtl/arp_responder_and_cache_unit.sv */
// ARP responder and address cache, top level; holds the port registers.
// Uses arc_pkg, arc_front, arc_queue and arc_back.
// Input transfers wait in the queue while the back end handles one command at a time;
// a lookup or store first searches the cached entries in turn, and a request sends
// one reply per matching enabled port.
// Synchronous reset empties the table and queue and clears the port registers.
`timescale 1ns / 1ps
`default_nettype none

module arp_responder_and_cache_unit #(
    parameter int TABLE_ENTRIES = arc_pkg::TABLE_ENTRIES_DEF,
    parameter int PORTS         = arc_pkg::PORTS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    // configuration writes
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic [2:0]     i_cfg_index,
    input  wire logic [47:0]    i_cfg_data,
    // input items
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire logic           i_kind,
    input  wire logic [15:0]    i_hw_type,
    input  wire logic [15:0]    i_proto_type,
    input  wire logic [7:0]     i_hw_len,
    input  wire logic [7:0]     i_proto_len,
    input  wire logic [15:0]    i_opcode,
    input  wire logic [47:0]    i_sender_mac,
    input  wire logic [31:0]    i_sender_ip,
    input  wire logic [31:0]    i_target_ip,
    input  wire logic [31:0]    i_lookup_ip,
    // result items
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output logic                o_result_kind,
    output logic [1:0]          o_reply_port,
    output logic [47:0]         o_reply_sender_mac,
    output logic [31:0]         o_reply_sender_ip,
    output logic [47:0]         o_reply_target_mac,
    output logic [31:0]         o_reply_target_ip,
    output logic                o_hit,
    output logic [47:0]         o_hit_mac,
    output logic                o_last
);

    logic [2:0]         r_port_enable;
    logic [47:0]        r_port_mac [PORTS];
    logic [31:0]        r_port_ip [PORTS];

    logic               push;
    logic               full;
    logic               pop;
    logic               avail;
    arc_pkg::t_item     front_item;
    arc_pkg::t_item     queue_item;
    arc_pkg::t_result   result;

    // Configuration register writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_enable <= '0;
            for (int p = 0; p < PORTS; p++) begin
                r_port_mac[p] <= '0;
                r_port_ip[p]  <= '0;
            end
        end else if (i_cfg_valid) begin
            if (i_cfg_index == arc_pkg::CFG_PORT_ENABLE) begin
                r_port_enable <= i_cfg_data[2:0];
            end
            for (int p = 0; p < PORTS; p++) begin
                if (i_cfg_index == arc_pkg::CFG_MAC_IDX[p]) begin
                    r_port_mac[p] <= i_cfg_data;
                end
                if (i_cfg_index == arc_pkg::CFG_IP_IDX[p]) begin
                    r_port_ip[p] <= i_cfg_data[31:0];
                end
            end
        end
    end

    arc_front u_front (
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_hw_type    (i_hw_type),
        .i_proto_type (i_proto_type),
        .i_hw_len     (i_hw_len),
        .i_proto_len  (i_proto_len),
        .i_opcode     (i_opcode),
        .i_sender_mac (i_sender_mac),
        .i_sender_ip  (i_sender_ip),
        .i_target_ip  (i_target_ip),
        .i_lookup_ip  (i_lookup_ip),
        .i_full       (full),
        .o_push       (push),
        .o_item       (front_item)
    );

    arc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_avail (avail),
        .o_item  (queue_item)
    );

    arc_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .PORTS         (PORTS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_avail       (avail),
        .i_item        (queue_item),
        .o_pop         (pop),
        .i_port_enable (r_port_enable),
        .i_port_mac    (r_port_mac),
        .i_port_ip     (r_port_ip),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_result      (result)
    );

    // Result fields
    assign o_result_kind      = result.result_kind;
    assign o_reply_port       = result.reply_port;
    assign o_reply_sender_mac = result.reply_sender_mac;
    assign o_reply_sender_ip  = result.reply_sender_ip;
    assign o_reply_target_mac = result.reply_target_mac;
    assign o_reply_target_ip  = result.reply_target_ip;
    assign o_hit              = result.hit;
    assign o_hit_mac          = result.hit_mac;
    assign o_last             = result.last;

endmodule

`default_nettype wire

/* bench/tb_arp_responder_and_cache_unit.sv */
// Testbench for arp_responder_and_cache_unit: directed and random ARP traffic
// checked against a scoreboard that tracks port registers and the IP-to-MAC cache.
// Depends on rtl/arc_pkg.sv and the unit's RTL.
`timescale 1ns / 1ps

module tb_arp_responder_and_cache_unit;
    import arc_pkg::*;

    localparam int          LONG_HOLD    = 400;
    localparam int          SETTLE       = 150;
    localparam int          POOL_SIZE    = 24;
    localparam int          TIMEOUT_NS   = 1_000_000;
    localparam logic [31:0] DIR_IP       = 32'hC0A8_0A01;
    localparam logic [31:0] BAD_IP       = 32'h0A0B_0C0D;

    typedef struct packed {
        logic        kind;
        logic [15:0] hw_type;
        logic [15:0] proto_type;
        logic [7:0]  hw_len;
        logic [7:0]  proto_len;
        logic [15:0] opcode;
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
        logic [31:0] target_ip;
        logic [31:0] lookup_ip;
    } arp_item_t;

    // Tracks port registers and the address cache; holds replies and answers in flight
    class arp_cache_scoreboard;
        logic [2:0]  port_en;
        logic [47:0] port_mac [PORT_SLOTS];
        logic [31:0] port_ip  [PORT_SLOTS];
        bit          entry_ok  [TABLE_ENTRIES_DEF];
        logic [31:0] entry_ip  [TABLE_ENTRIES_DEF];
        logic [47:0] entry_mac [TABLE_ENTRIES_DEF];
        int          fill;
        t_result     awaited_results [$];
        int          errors;
        int          seen;

        function new();
            port_en = '0;
            fill    = 0;
            errors  = 0;
            seen    = 0;
            foreach (port_mac[p]) begin
                port_mac[p] = '0;
                port_ip[p]  = '0;
            end
            foreach (entry_ok[i]) entry_ok[i] = 1'b0;
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        function void write_reg(logic [2:0] idx, logic [47:0] data);
            case (idx)
                CFG_PORT_ENABLE: port_en     = data[2:0];
                CFG_PORT_MAC_0:  port_mac[0] = data;
                CFG_PORT_IP_0:   port_ip[0]  = data[31:0];
                CFG_PORT_MAC_1:  port_mac[1] = data;
                CFG_PORT_IP_1:   port_ip[1]  = data[31:0];
                CFG_PORT_MAC_2:  port_mac[2] = data;
                CFG_PORT_IP_2:   port_ip[2]  = data[31:0];
                default: ;
            endcase
        endfunction

        function int find_cached(logic [31:0] ip);
            for (int i = 0; i < TABLE_ENTRIES_DEF; i++)
                if (entry_ok[i] && entry_ip[i] == ip) return i;
            return -1;
        endfunction

        // Update in place, else take the next free slot; full table drops it
        function void cache_learn(logic [31:0] ip, logic [47:0] mac);
            int i;
            i = find_cached(ip);
            if (i < 0 && fill < TABLE_ENTRIES_DEF) begin
                i           = fill;
                entry_ok[i] = 1'b1;
                entry_ip[i] = ip;
                fill++;
            end
            if (i >= 0) entry_mac[i] = mac;
        endfunction

        // Works out the results of one accepted transfer
        function void predict_arp_results(arp_item_t it);
            t_result r;
            int      hits [$];
            int      i;
            r = '0;
            if (it.kind == KIND_LOOKUP) begin
                i             = find_cached(it.lookup_ip);
                r.result_kind = RESULT_LOOKUP;
                r.hit         = (i >= 0);
                if (i >= 0) r.hit_mac = entry_mac[i];
                r.last = 1'b1;
                awaited_results.push_back(r);
                return;
            end
            if (it.hw_type != HW_TYPE_ETH || it.proto_type != PROTO_TYPE_IPV4 ||
                it.hw_len != HW_LEN_MAC || it.proto_len != PROTO_LEN_IPV4)
                return;
            if (it.opcode == OP_REQUEST) begin
                for (int p = 0; p < PORTS_DEF; p++)
                    if (port_en[p] && port_ip[p] == it.target_ip) hits.push_back(p);
                foreach (hits[k]) begin
                    r.result_kind      = RESULT_REPLY;
                    r.reply_port       = 2'(hits[k]);
                    r.reply_sender_mac = port_mac[hits[k]];
                    r.reply_sender_ip  = port_ip[hits[k]];
                    r.reply_target_mac = it.sender_mac;
                    r.reply_target_ip  = it.sender_ip;
                    r.last             = (k == hits.size() - 1);
                    awaited_results.push_back(r);
                end
                return;
            end
            if (it.opcode == OP_REPLY) begin
                cache_learn(it.sender_ip, it.sender_mac);
            end
        endfunction

        task check_result(t_result got);
            t_result want;
            string   bad;
            seen++;
            if (awaited_results.size() == 0) begin
                report($sformatf("result %0d with nothing outstanding: %h", seen, got));
                return;
            end
            want = awaited_results.pop_front();
            bad  = "";
            if (got.result_kind !== want.result_kind) bad = {bad, " result_kind"};
            if (got.reply_port !== want.reply_port) bad = {bad, " reply_port"};
            if (got.reply_sender_mac !== want.reply_sender_mac) bad = {bad, " sender_mac"};
            if (got.reply_sender_ip !== want.reply_sender_ip) bad = {bad, " sender_ip"};
            if (got.reply_target_mac !== want.reply_target_mac) bad = {bad, " target_mac"};
            if (got.reply_target_ip !== want.reply_target_ip) bad = {bad, " target_ip"};
            if (got.hit !== want.hit) bad = {bad, " hit"};
            if (got.hit_mac !== want.hit_mac) bad = {bad, " hit_mac"};
            if (got.last !== want.last) bad = {bad, " last"};
            if (bad != "")
                report($sformatf("result %0d:%s got %h want %h", seen, bad, got, want));
        endtask
    endclass

    // DUT signals; the inputs are known from time zero
    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_valid  = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index  = '0;
    logic [47:0] i_cfg_data   = '0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_ready;
    logic        i_kind       = 1'b0;
    logic [15:0] i_hw_type    = '0;
    logic [15:0] i_proto_type = '0;
    logic [7:0]  i_hw_len     = '0;
    logic [7:0]  i_proto_len  = '0;
    logic [15:0] i_opcode     = '0;
    logic [47:0] i_sender_mac = '0;
    logic [31:0] i_sender_ip  = '0;
    logic [31:0] i_target_ip  = '0;
    logic [31:0] i_lookup_ip  = '0;
    logic        o_out_valid;
    logic        i_out_ready  = 1'b0;
    logic        o_result_kind;
    logic [1:0]  o_reply_port;
    logic [47:0] o_reply_sender_mac;
    logic [31:0] o_reply_sender_ip;
    logic [47:0] o_reply_target_mac;
    logic [31:0] o_reply_target_ip;
    logic        o_hit;
    logic [47:0] o_hit_mac;
    logic        o_last;

    arp_cache_scoreboard sb;
    int                  send_idle    = 15;
    int                  recv_idle    = 77;
    int                  stall_orders = 0;
    int                  stall_taken  = 0;
    int                  hold_left    = 0;
    logic [31:0]         ip_pool [POOL_SIZE];

    arp_responder_and_cache_unit uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_kind             (i_kind),
        .i_hw_type          (i_hw_type),
        .i_proto_type       (i_proto_type),
        .i_hw_len           (i_hw_len),
        .i_proto_len        (i_proto_len),
        .i_opcode           (i_opcode),
        .i_sender_mac       (i_sender_mac),
        .i_sender_ip        (i_sender_ip),
        .i_target_ip        (i_target_ip),
        .i_lookup_ip        (i_lookup_ip),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_result_kind      (o_result_kind),
        .o_reply_port       (o_reply_port),
        .o_reply_sender_mac (o_reply_sender_mac),
        .o_reply_sender_ip  (o_reply_sender_ip),
        .o_reply_target_mac (o_reply_target_mac),
        .o_reply_target_ip  (o_reply_target_ip),
        .o_hit              (o_hit),
        .o_hit_mac          (o_hit_mac),
        .o_last             (o_last)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Result side: check each transfer, drive ready with random gaps or a long hold
    always @(posedge i_clk) begin
        t_result got;
        got = {o_result_kind, o_reply_port, o_reply_sender_mac, o_reply_sender_ip,
               o_reply_target_mac, o_reply_target_ip, o_hit, o_hit_mac, o_last};
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(got);
        if (stall_taken != stall_orders) begin
            stall_taken = stall_orders;
            hold_left   = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left   = hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [31:0] pool_ip();
        return ip_pool[$urandom_range(POOL_SIZE - 1)];
    endfunction

    function automatic arp_item_t arp_packet(logic [15:0] op, logic [47:0] smac,
                                             logic [31:0] sip, logic [31:0] tip);
        arp_item_t it;
        it            = '0;
        it.kind       = KIND_PACKET;
        it.hw_type    = HW_TYPE_ETH;
        it.proto_type = PROTO_TYPE_IPV4;
        it.hw_len     = HW_LEN_MAC;
        it.proto_len  = PROTO_LEN_IPV4;
        it.opcode     = op;
        it.sender_mac = smac;
        it.sender_ip  = sip;
        it.target_ip  = tip;
        it.lookup_ip  = $urandom;
        return it;
    endfunction

    function automatic arp_item_t lookup_of(logic [31:0] ip);
        arp_item_t it;
        it           = '0;
        it.kind      = KIND_LOOKUP;
        it.lookup_ip = ip;
        return it;
    endfunction

    // Mostly well-formed traffic around the current port IPs and an IP pool
    function automatic arp_item_t make_item();
        arp_item_t it;
        int        pick;
        it = {1'b0, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
              16'($urandom), rand48(), 32'($urandom), 32'($urandom), 32'($urandom)};
        pick = $urandom_range(99);
        if (pick < 30) begin
            it.kind      = KIND_LOOKUP;
            it.lookup_ip = ($urandom_range(99) < 85) ? pool_ip() : 32'($urandom);
        end else if (pick < 60) begin
            it = arp_packet(OP_REQUEST, it.sender_mac, it.sender_ip,
                            ($urandom_range(99) < 70) ?
                            sb.port_ip[$urandom_range(PORT_SLOTS - 1)] : pool_ip());
        end else if (pick < 85) begin
            it = arp_packet(OP_REPLY, it.sender_mac, pool_ip(), it.target_ip);
        end else begin
            // noise: a near-valid packet with one field broken
            it = arp_packet($urandom_range(1) ? OP_REQUEST : OP_REPLY, it.sender_mac,
                            pool_ip(), sb.port_ip[$urandom_range(PORT_SLOTS - 1)]);
            case ($urandom_range(5))
                0: it.hw_type    = 16'($urandom);
                1: it.proto_type = 16'($urandom);
                2: it.hw_len     = 8'($urandom);
                3: it.proto_len  = 8'($urandom);
                4: it.opcode     = {it.opcode[7:0], it.opcode[15:8]};
                default: it.opcode = 16'($urandom);
            endcase
        end
        return it;
    endfunction

    task automatic cfg_write(input logic [2:0] idx, input logic [47:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_ports(input logic [2:0] en,
                             input logic [47:0] mac0, input logic [31:0] ip0,
                             input logic [47:0] mac1, input logic [31:0] ip1,
                             input logic [47:0] mac2, input logic [31:0] ip2);
        cfg_write(CFG_PORT_ENABLE, 48'(en));
        cfg_write(CFG_PORT_MAC_0, mac0);
        cfg_write(CFG_PORT_IP_0, 48'(ip0));
        cfg_write(CFG_PORT_MAC_1, mac1);
        cfg_write(CFG_PORT_IP_1, 48'(ip1));
        cfg_write(CFG_PORT_MAC_2, mac2);
        cfg_write(CFG_PORT_IP_2, 48'(ip2));
    endtask

    // Valid stays up after a transfer; the next call either re-drives or drops it
    task automatic send_item(input arp_item_t it);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= it.kind;
        i_hw_type    <= it.hw_type;
        i_proto_type <= it.proto_type;
        i_hw_len     <= it.hw_len;
        i_proto_len  <= it.proto_len;
        i_opcode     <= it.opcode;
        i_sender_mac <= it.sender_mac;
        i_sender_ip  <= it.sender_ip;
        i_target_ip  <= it.target_ip;
        i_lookup_ip  <= it.lookup_ip;
        do @(posedge i_clk); while (!o_in_ready);
        sb.predict_arp_results(it);
    endtask

    task automatic send_random(input int n);
        repeat (n) send_item(make_item());
    endtask

    // Stop offering until all outstanding results are back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.awaited_results.size() > 0) @(posedge i_clk);
    endtask

    // Drain, then give queued table stores time to land
    task automatic settle();
        drain();
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        arp_item_t script [$];
        arp_item_t d;

        sb = new();
        ip_pool[0] = '0;
        ip_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) ip_pool[i] = $urandom;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: all three ports share one IP so a request gets three replies
        set_ports(3'b111, '1, DIR_IP, '0, DIR_IP, rand48(), DIR_IP);
        script.push_back(lookup_of('0));
        script.push_back(lookup_of('1));
        script.push_back(arp_packet(OP_REQUEST, '1, '0, DIR_IP));
        script.push_back(arp_packet(OP_REQUEST, rand48(), $urandom, DIR_IP + 1));
        script.push_back(arp_packet(OP_REPLY, '1, '0, DIR_IP));
        script.push_back(arp_packet(OP_REPLY, '0, '1, DIR_IP));
        script.push_back(lookup_of('0));
        script.push_back(lookup_of('1));
        script.push_back(arp_packet(OP_REPLY, 48'h1234_5678_9ABC, '0, DIR_IP));
        script.push_back(lookup_of('0));
        // opcodes in host byte order must not match
        script.push_back(arp_packet({OP_REQUEST[7:0], OP_REQUEST[15:8]}, '1, '0, DIR_IP));
        script.push_back(arp_packet({OP_REPLY[7:0], OP_REPLY[15:8]}, rand48(), '0, DIR_IP));
        script.push_back(lookup_of('0));
        script.push_back(arp_packet(16'h0000, rand48(), BAD_IP, DIR_IP));
        script.push_back(arp_packet(16'h0003, rand48(), BAD_IP, DIR_IP));
        script.push_back(arp_packet(16'hFFFF, rand48(), BAD_IP, DIR_IP));
        // malformed headers
        d = arp_packet(OP_REQUEST, rand48(), BAD_IP, DIR_IP);
        d.hw_type = {HW_TYPE_ETH[7:0], HW_TYPE_ETH[15:8]};
        script.push_back(d);
        d = arp_packet(OP_REPLY, rand48(), BAD_IP, DIR_IP);
        d.proto_type = {PROTO_TYPE_IPV4[7:0], PROTO_TYPE_IPV4[15:8]};
        script.push_back(d);
        d = arp_packet(OP_REPLY, rand48(), BAD_IP, DIR_IP);
        d.hw_len = '0;
        script.push_back(d);
        d = arp_packet(OP_REQUEST, rand48(), BAD_IP, DIR_IP);
        d.hw_len = '1;
        script.push_back(d);
        d = arp_packet(OP_REPLY, rand48(), BAD_IP, DIR_IP);
        d.proto_len = HW_LEN_MAC;
        script.push_back(d);
        script.push_back(lookup_of(BAD_IP));
        script.push_back(arp_packet(OP_REQUEST, '0, '1, DIR_IP));
        foreach (script[i]) send_item(script[i]);
        settle();

        // Random, sender mostly busy, receiver mostly stalled
        set_ports(3'b101, rand48(), $urandom, rand48(), $urandom, '1, '1);
        send_random(50);
        settle();

        // Roles swapped; ports 1 and 2 share an IP
        send_idle = 77;
        recv_idle = 15;
        d.target_ip = $urandom;
        set_ports(3'b110, rand48(), $urandom, rand48(), d.target_ip, rand48(), d.target_ip);
        send_random(50);
        settle();

        // No idling; long receiver hold fills the unit, then a full pause
        send_idle = 0;
        recv_idle = 0;
        set_ports(3'b111, rand48(), '0, rand48(), $urandom, rand48(), $urandom);
        stall_orders++;
        send_random(30);
        drain();
        send_random(15);
        settle();

        // All ports off, registers at zero
        set_ports(3'b000, '0, '0, '0, '0, '0, '0);
        send_random(15);
        settle();

        if (sb.awaited_results.size() > 0)
            sb.report($sformatf("%0d results never arrived", sb.awaited_results.size()));
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

endmodule
